// File: rtl/box_non_maximum_suppression_defines.svh
// ---------------------------------------------------------------------------
// box_non_maximum_suppression_defines.svh
// Assertion macros shared by the suppression block.
// ---------------------------------------------------------------------------
`ifndef BOX_NON_MAXIMUM_SUPPRESSION_DEFINES_SVH
`define BOX_NON_MAXIMUM_SUPPRESSION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define NMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/nms_pkg.sv
// ---------------------------------------------------------------------------
// nms_pkg
// Types and constants of the box non-maximum suppression block.
// ---------------------------------------------------------------------------
package nms_pkg;

   localparam int MAX_KEPT    = 64;
   localparam int SLOT_W      = $clog2(MAX_KEPT);
   localparam int CNT_W       = $clog2(MAX_KEPT + 1);
   localparam int KEPT_SLOT_W = 6;
   localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

   typedef struct packed {
      logic [15:0] box_x;
      logic [15:0] box_y;
      logic [15:0] box_width;
      logic [15:0] box_height;
      logic        last_box;
   } req_type;

   typedef struct packed {
      logic                   keep;
      logic [KEPT_SLOT_W-1:0] kept_slot;
      logic                   table_full;
   } rsp_type;

   // One picked-table entry: box geometry and its area.
   typedef struct packed {
      logic [31:0] area;
      logic [15:0] box_height;
      logic [15:0] box_width;
      logic [15:0] box_y;
      logic [15:0] box_x;
   } entry_type;

   // Status from the overlap unit back to the sequencer.
   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic suppress;
   } ovl_status_type;

endpackage

// File: rtl/nms_overlap_unit.sv
// ---------------------------------------------------------------------------
// nms_overlap_unit
// Pipelined IoU test of the current box against one picked entry per cycle.
// ---------------------------------------------------------------------------
module nms_overlap_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  nms_pkg::req_type        box,
   input  logic [31:0]             area,
   input  logic [15:0]             threshold,
   input  nms_pkg::entry_type      entry,
   output nms_pkg::ovl_status_type status
);
   import nms_pkg::*;

   function automatic logic [15:0] overlap_1d(input logic [15:0] a0, input logic [15:0] alen,
                                              input logic [15:0] b0, input logic [15:0] blen);
      logic [16:0] ae;
      logic [16:0] be;
      logic [16:0] hi;
      logic [16:0] lo;
      ae = {1'b0, a0} + {1'b0, alen};
      be = {1'b0, b0} + {1'b0, blen};
      hi = (ae < be) ? ae : be;
      lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
      overlap_1d = (hi > lo) ? 16'(hi - lo) : 16'd0;
   endfunction

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [15:0] ox_ff, oy_ff;
   logic [31:0] pa1_ff, pa2_ff;
   logic [31:0] inter2_ff, inter3_ff, inter4_ff;
   logic [32:0] uni3_ff;
   logic [48:0] prod4_ff;

   logic [15:0] ox_in, oy_in;
   logic [31:0] inter_in;
   logic [32:0] uni_in;
   logic [48:0] prod_in;

   assign ox_in    = overlap_1d(box.box_x, box.box_width, entry.box_x, entry.box_width);
   assign oy_in    = overlap_1d(box.box_y, box.box_height, entry.box_y, entry.box_height);
   assign inter_in = {16'd0, ox_ff} * {16'd0, oy_ff};
   assign uni_in   = {1'b0, area} + {1'b0, pa2_ff} - {1'b0, inter2_ff};
   assign prod_in  = {33'd0, threshold} * {16'd0, uni3_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      pa1_ff    <= entry.area;
      inter2_ff <= inter_in;
      pa2_ff    <= pa1_ff;
      inter3_ff <= inter2_ff;
      uni3_ff   <= uni_in;
      inter4_ff <= inter3_ff;
      prod4_ff  <= prod_in;
   end

   // Suppress when inter * 2^16 exceeds threshold * union.
   assign status.hit_valid = v4_ff;
   assign status.suppress  = {1'b0, inter4_ff, 16'h0000} > prod4_ff;
   assign status.busy      = v1_ff | v2_ff | v3_ff | v4_ff;

endmodule

// File: rtl/box_non_maximum_suppression.sv
// ---------------------------------------------------------------------------
// box_non_maximum_suppression
// Greedy IoU non-maximum suppression over one frame of score-sorted boxes.
// ---------------------------------------------------------------------------
// Boxes arrive one request at a time, already sorted by descending score.
// Each one is tested against every box picked so far in the frame by a single
// pipelined overlap unit fed from the picked-table memory, one entry per
// cycle. After the request is accepted the block forms the area product,
// reads every picked entry of the table (up to 64), leaves the scan, waits
// while the four-stage overlap pipeline drains, and loads the result. With
// an empty table there are no reads. Once the result is loaded the block
// returns to idle and can take the next request. The block takes no new
// request while a box is in flight, but a finished result may wait in the
// output register while the next request is accepted; that next box then
// holds its result until the output register is free. A box survives if,
// against every picked box, inter * 65536 <= iou_threshold * union; a
// survivor is appended and reported with its slot, or flagged table_full
// when all slots are taken. The box marked last_box empties the table
// after its own result. The user must write the threshold through
// csr_wr_en/csr_wr_data only while the block is idle; the block itself
// does not enforce this.
// ---------------------------------------------------------------------------
`include "box_non_maximum_suppression_defines.svh"

module box_non_maximum_suppression (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nms_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);
   import nms_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_AREA  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic [15:0]    thr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic           sup_ff, sup_in;
   logic           rd_valid_ff, rd_en;
   entry_type      rd_data_ff;
   req_type        box_ff;
   logic [31:0]    area_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic           wr_en;
   ovl_status_type ovl_status;
   logic           req_fire, done_fire, survive, room;

   // Picked table: box geometry plus area, read one entry per scan cycle.
   entry_type mem [MAX_KEPT];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rd_en     = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign survive   = !sup_ff;
   assign room      = (count_ff < CNT_W'(MAX_KEPT));
   assign wr_en     = done_fire && survive && room;

   // Sequencer: area, scan the table, drain the overlap pipe, report.
   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      sup_in   = sup_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_AREA;
               sup_in   = 1'b0;
            end
         end
         ST_AREA: begin
            state_in = ST_SCAN;
            issue_in = '0;
         end
         ST_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !ovl_status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               state_in = ST_IDLE;
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
               // Empty the table after the frame's final box.
               if (box_ff.last_box) begin
                  count_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Fold each overlap verdict into the suppress flag.
      if (ovl_status.hit_valid && ovl_status.suppress) begin
         sup_in = 1'b1;
      end
   end

   // Output register: load on completion, drop once taken.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (done_fire) begin
         rsp_valid_in       = 1'b1;
         rsp_in.keep        = wr_en;
         rsp_in.kept_slot   = wr_en ? KEPT_SLOT_W'(count_ff) : '0;
         rsp_in.table_full  = survive && !room;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= IOU_THRESHOLD_RESET;
         count_ff     <= '0;
         issue_ff     <= '0;
         sup_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         sup_ff       <= sup_in;
         rd_valid_ff  <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers: hold the request, its area and the result.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         box_ff <= req_data;
      end
      if (state_ff == ST_AREA) begin
         area_ff <= {16'd0, box_ff.box_width} * {16'd0, box_ff.box_height};
      end
      rsp_ff <= rsp_in;
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[SLOT_W-1:0]] <= '{area:       area_ff,
                                        box_height: box_ff.box_height,
                                        box_width:  box_ff.box_width,
                                        box_y:      box_ff.box_y,
                                        box_x:      box_ff.box_x};
      end
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[SLOT_W-1:0]];
      end
   end

   nms_overlap_unit u_overlap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .box       (box_ff),
      .area      (area_ff),
      .threshold (thr_ff),
      .entry     (rd_data_ff),
      .status    (ovl_status)
   );

   // Table never grows beyond its capacity.
   `NMS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_KEPT))
   // A result is never both kept and flagged full.
   `NMS_ASSERT_NOW(a_keep_full_excl, clock, reset, rsp_valid_ff,
                   !(rsp_ff.keep && rsp_ff.table_full))
   // An accepted request starts with the area step.
   `NMS_ASSERT_NEXT(a_accept_area, clock, reset, req_fire, state_ff == ST_AREA)
   // No overlap verdict may arrive once the block is back to idle.
   `NMS_ASSERT_NOW(a_idle_quiet, clock, reset, state_ff == ST_IDLE,
                   !ovl_status.busy && !rd_valid_ff)

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy IoU box suppression block.
// ----------------------------------------------------------------------------
// Boxes go in as frames of requests with random gaps. A predictor built into
// the bench keeps its own picked table and threshold. For each accepted box it
// queues the verdict it expects: kept with its slot, suppressed, or flagged
// because the table is full. The response side stalls at random, checks every
// accepted verdict against the oldest queued one, and once holds off long
// enough to back the block up. The threshold is rewritten between phases,
// always with the block idle, and covers both extremes.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nms_pkg::*;

   // Shapes of generated boxes.
   typedef enum int {KIND_TILE, KIND_CLUSTER, KIND_ANY, KIND_EMPTY} box_kind_type;

   localparam int TILE_PITCH   = 'h2000;   // 8x8 grid of disjoint tiles
   localparam int SETTLE_TICKS = 4;
   localparam int DRAIN_TICKS  = 100;      // above the worst-case box latency
   localparam int BOX_TARGET   = 550;
   localparam int REPORT_MAX   = 10;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // Predictor copy of the picked table and the threshold.
   req_type     picked_box  [MAX_KEPT];
   logic [31:0] picked_area [MAX_KEPT];
   int          picked_total = 0;
   logic [15:0] iou_limit    = IOU_THRESHOLD_RESET;

   rsp_type     pending_verdicts [$];
   int          fail_count      = 0;
   int          boxes_sent      = 0;
   bit          req_held        = 1'b0;   // req_valid still high after an accept
   bit          req_gaps_on     = 1'b1;
   bit          rsp_gaps_on     = 1'b1;
   int          rsp_hold_request = 0;     // long hold-off asked of the response side
   int          rsp_stall_left  = 0;
   req_type     cluster_base;
   int          tile_next       = 0;

   always #4 clock = ~clock;

   box_non_maximum_suppression i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Overlap of two spans along one axis; ends are 17 bit, never wrap.
   function automatic logic [16:0] axis_overlap(logic [15:0] a0, logic [15:0] alen,
                                                logic [15:0] b0, logic [15:0] blen);
      logic [16:0] lo, hi, a_end, b_end;
      a_end = {1'b0, a0} + {1'b0, alen};
      b_end = {1'b0, b0} + {1'b0, blen};
      lo    = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
      hi    = (a_end < b_end) ? a_end : b_end;
      return (hi > lo) ? hi - lo : '0;
   endfunction

   // Compute the verdict for one box and advance the picked table.
   function automatic rsp_type predict_suppression(req_type b);
      rsp_type     r;
      logic [63:0] area, inter, union_sz;
      bit          survive;
      int          j;
      r       = '0;
      survive = 1'b1;
      area    = {48'd0, b.box_width} * {48'd0, b.box_height};
      for (j = 0; j < picked_total; j++) begin
         inter = {47'd0, axis_overlap(b.box_x, b.box_width,
                                      picked_box[j].box_x, picked_box[j].box_width)}
               * {47'd0, axis_overlap(b.box_y, b.box_height,
                                      picked_box[j].box_y, picked_box[j].box_height)};
         union_sz = area + {32'd0, picked_area[j]} - inter;
         // Cross-multiplied IoU test; a zero union never suppresses.
         if ((inter << 16) > {48'd0, iou_limit} * union_sz)
            survive = 1'b0;
      end
      if (survive) begin
         if (picked_total < MAX_KEPT) begin
            picked_box[picked_total]  = b;
            picked_area[picked_total] = area[31:0];
            r.keep      = 1'b1;
            r.kept_slot = picked_total[KEPT_SLOT_W-1:0];
            picked_total++;
         end else begin
            r.table_full = 1'b1;
         end
      end
      if (b.last_box)
         picked_total = 0;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Box generation
   // ------------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
   endfunction

   function automatic req_type box_at(logic [15:0] x, logic [15:0] y,
                                      logic [15:0] w, logic [15:0] h, bit last);
      req_type b;
      b.box_x      = x;
      b.box_y      = y;
      b.box_width  = w;
      b.box_height = h;
      b.last_box   = last;
      return b;
   endfunction

   // Pick a new center of overlapping boxes.
   function automatic void new_cluster();
      cluster_base.box_x      = 16'($urandom_range(0, 60000));
      cluster_base.box_y      = 16'($urandom_range(0, 60000));
      cluster_base.box_width  = 16'($urandom_range(256, 8191));
      cluster_base.box_height = 16'($urandom_range(256, 8191));
      cluster_base.last_box   = 1'b0;
   endfunction

   function automatic box_kind_type pick_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return KIND_CLUSTER;
      else if (roll < 75)
         return KIND_TILE;
      else if (roll < 90)
         return KIND_ANY;
      return KIND_EMPTY;
   endfunction

   function automatic req_type make_box(box_kind_type kind, bit last);
      req_type b;
      b = '0;
      case (kind)
         KIND_TILE: begin
            // Stay inside the tile so tiles never touch each other.
            b.box_x      = 16'((tile_next % 8) * TILE_PITCH + $urandom_range(0, 1023));
            b.box_y      = 16'((tile_next / 8) * TILE_PITCH + $urandom_range(0, 1023));
            b.box_width  = 16'($urandom_range(1, 7000));
            b.box_height = 16'($urandom_range(1, 7000));
            tile_next    = (tile_next + 1) % MAX_KEPT;
         end
         KIND_CLUSTER: begin
            // Jitter around the cluster center; the 16-bit wrap is intended.
            b.box_x      = 16'(cluster_base.box_x + $urandom_range(0, 512) - 256);
            b.box_y      = 16'(cluster_base.box_y + $urandom_range(0, 512) - 256);
            b.box_width  = 16'(cluster_base.box_width + $urandom_range(0, 512) - 256);
            b.box_height = 16'(cluster_base.box_height + $urandom_range(0, 512) - 256);
         end
         KIND_ANY: begin
            b.box_x      = 16'($urandom);
            b.box_y      = 16'($urandom);
            b.box_width  = 16'($urandom);
            b.box_height = 16'($urandom);
         end
         default: begin
            // Zero width, zero height or both.
            b.box_x      = 16'($urandom);
            b.box_y      = 16'($urandom);
            b.box_width  = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
            b.box_height = (b.box_width != 0 || $urandom_range(0, 1) == 0)
                         ? 16'd0 : 16'($urandom);
         end
      endcase
      b.last_box = last;
      return b;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one box, hold it until accepted, then queue its verdict.
   // req_valid stays high on return so that a back-to-back box needs no toggle.
   task automatic send_box(req_type b);
      int      gap;
      rsp_type verdict;
      gap = (req_gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         if (req_held)
            req_valid <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      verdict          = predict_suppression(b);
      pending_verdicts = {pending_verdicts, verdict};
      boxes_sent++;
      req_held = 1'b1;
   endtask

   // Drop the request, then wait until every verdict is back.
   task automatic wait_idle();
      if (req_held)
         req_valid <= 1'b0;
      req_held = 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_iou_limit(logic [15:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      iou_limit   = value;
   endtask

   // Send one frame of random content; optionally leave it open.
   task automatic send_frame(int length, bit close_frame);
      int i;
      new_cluster();
      tile_next = $urandom_range(0, MAX_KEPT - 1);
      for (i = 0; i < length; i++) begin
         if ($urandom_range(0, 7) == 0)
            new_cluster();
         send_box(make_box(pick_kind(), close_frame && i == length - 1));
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: check each accepted verdict, drive random stalls
   // ------------------------------------------------------------------------

   task automatic log_mismatch(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("%0t %s: expected %0d/%0d/%0d, got %0d/%0d/%0d (keep/slot/full)",
                  $realtime, what, want.keep, want.kept_slot, want.table_full,
                  got.keep, got.kept_slot, got.table_full);
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            log_mismatch("unexpected", '0, rsp_data);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.keep       !== want.keep      ||
                rsp_data.kept_slot  !== want.kept_slot ||
                rsp_data.table_full !== want.table_full)
               log_mismatch("verdict", want, rsp_data);
         end
      end
      // Start a requested hold-off, else draw a random stall.
      if (rsp_hold_request > 0) begin
         rsp_stall_left   = rsp_hold_request;
         rsp_hold_request = 0;
      end else if (rsp_stall_left == 0 && rsp_gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_stall_left = idle_length();
      end
      if (rsp_stall_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Field extremes, zero-size boxes, zero union, identical boxes, frame end.
   task automatic test_field_extremes();
      send_box(box_at(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));   // empty table
      send_box(box_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));   // 17-bit edges
      send_box(box_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));   // identical
      send_box(box_at(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));   // zero union
      send_box(box_at(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
      send_box(box_at(16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
      send_box(box_at(16'h0001, 16'h0001, 16'hFFFE, 16'hFFFE, 1'b1));   // close frame
      // Table must be empty again.
      send_box(box_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
      send_box(box_at(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0));
      send_box(box_at(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0));
      send_box(box_at(16'h1234, 16'h4321, 16'h0000, 16'h0100, 1'b1));
      send_box(box_at(16'h7FFF, 16'h8000, 16'h0001, 16'h0001, 1'b1));   // lone last box
   endtask

   // Threshold at zero and at full scale.
   task automatic test_threshold_extremes();
      write_iou_limit(16'h0000);
      // Any overlap at all suppresses; touching edges do not.
      send_box(box_at(16'h1000, 16'h1000, 16'h0100, 16'h0100, 1'b0));
      send_box(box_at(16'h10FF, 16'h1000, 16'h0100, 16'h0100, 1'b0));
      send_box(box_at(16'h1100, 16'h1000, 16'h0100, 16'h0100, 1'b1));
      write_iou_limit(16'hFFFF);
      // Only an exact match exceeds the top threshold.
      send_box(box_at(16'h1000, 16'h1000, 16'h0100, 16'h0100, 1'b0));
      send_box(box_at(16'h1000, 16'h1000, 16'h0100, 16'h0100, 1'b0));
      send_box(box_at(16'h1000, 16'h1000, 16'h0101, 16'h0100, 1'b1));
      write_iou_limit(IOU_THRESHOLD_RESET);
   endtask

   // Fill all slots with disjoint boxes, then overflow.
   task automatic test_table_full();
      req_type first;
      int      i;
      write_iou_limit(16'($urandom_range(0, 65535)));
      tile_next = 0;
      first = make_box(KIND_TILE, 1'b0);
      send_box(first);
      for (i = 1; i < MAX_KEPT; i++)
         send_box(make_box(KIND_TILE, 1'b0));
      // Zero size overlaps nothing, so it survives into a full table.
      send_box(box_at(16'($urandom), 16'($urandom), 16'h0000, 16'($urandom), 1'b0));
      send_box(make_box(KIND_TILE, 1'b0));
      send_box(first);
      send_box(box_at(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000, 1'b1));
   endtask

   // Hold the response side off long enough to fill the block.
   task automatic test_backpressure();
      wait_idle();
      req_gaps_on      = 1'b0;
      rsp_gaps_on      = 1'b0;
      rsp_hold_request = 400;
      send_frame(12, 1'b1);
      wait_idle();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // Random frames over a series of thresholds.
   task automatic test_random_frames();
      int          phase;
      int          frames;
      logic [15:0] limit;
      phase = 0;
      while (boxes_sent < BOX_TARGET) begin
         case (phase % 6)
            0:       limit = IOU_THRESHOLD_RESET;
            1:       limit = 16'h0000;
            2:       limit = 16'hFFFF;
            3:       limit = 16'h8000;
            default: limit = 16'($urandom_range(0, 65535));
         endcase
         write_iou_limit(limit);
         // Keep one phase free of gaps on both sides.
         req_gaps_on = (phase != 4);
         rsp_gaps_on = (phase != 4);
         for (frames = 0; frames < 4 && boxes_sent < BOX_TARGET; frames++) begin
            if ($urandom_range(0, 9) == 0)
               send_frame($urandom_range(60, 72), 1'b1);
            else
               send_frame($urandom_range(1, 16), $urandom_range(0, 7) != 0);
         end
         phase++;
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_threshold_extremes();
      test_table_full();
      test_backpressure();
      test_random_frames();
      wait_idle();
      repeat (DRAIN_TICKS) @(posedge clock);
      if (fail_count == 0 && pending_verdicts.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Give up well past the slowest legal run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: box_non_maximum_suppression.f
+incdir+rtl
rtl/nms_pkg.sv
rtl/nms_overlap_unit.sv
rtl/box_non_maximum_suppression.sv
test/tb.sv
